/* hdl/svg_pkg.sv */
// svg_pkg: shared constants and types for the seeded variance generator
// generator seeding constants, tempering masks, register indexes, opcodes
// no dependencies
package svg_pkg;

	localparam int OUT_FRAC_BITS_DEF = 24;

	localparam int HALF_RANGE_W = 24;
	localparam int SCALE_W      = 17;

	localparam int          MT_M      = 397;
	localparam logic [31:0] MT_MULT   = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

	localparam logic REG_BASE_SEED      = 1'b0;
	localparam logic REG_VARIANCE_SCALE = 1'b1;

	localparam logic OP_MULT = 1'b0;
	localparam logic OP_RAW  = 1'b1;

	typedef struct packed {
		logic [HALF_RANGE_W-1:0] half_range;
		logic                    opcode;
	} svg_side_t;

endpackage

/* hdl/svg_mt_chain.sv */
// svg_mt_chain: pipelined generator seeding, one seeding step per stage,
// followed by the first-word twist and tempering stage
// depends on svg_pkg
module svg_mt_chain import svg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] in_seed,
	input  svg_side_t   in_side,
	output logic        out_valid,
	output logic [31:0] out_word,
	output svg_side_t   out_side
);

	logic        vld_s  [0:MT_M];
	logic [31:0] st_s   [0:MT_M];
	svg_side_t   side_s [0:MT_M];
	logic [31:0] mix_s  [1:MT_M];

	assign vld_s[0]  = in_valid;
	assign st_s[0]   = in_seed;
	assign side_s[0] = in_side;

	for (genvar i = 1; i <= MT_M; i++) begin : g_step
		logic [31:0] prev;
		logic [31:0] nxt;

		assign prev = st_s[i-1];
		assign nxt  = MT_MULT * (prev ^ (prev >> 30)) + 32'(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			st_s[i]   <= nxt;
			side_s[i] <= side_s[i-1];
		end

		if (i == 1) begin : g_mix_first
			always_ff @(posedge clk) begin
				mix_s[i] <= {prev[31], nxt[30:0]};
			end
		end else begin : g_mix_pass
			always_ff @(posedge clk) begin
				mix_s[i] <= mix_s[i-1];
			end
		end
	end

	logic [31:0] y0, y1, y2, y3, y4;

	always_comb begin
		y0 = st_s[MT_M] ^ (mix_s[MT_M] >> 1) ^ (mix_s[MT_M][0] ? MT_MATRIX : 32'h0);
		y1 = y0 ^ (y0 >> 11);
		y2 = y1 ^ ((y1 << 7) & TEMPER_B);
		y3 = y2 ^ ((y2 << 15) & TEMPER_C);
		y4 = y3 ^ (y3 >> 18);
	end

	logic        tw_vld_s;
	logic [31:0] tw_word_s;
	svg_side_t   tw_side_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_vld_s <= 1'b0;
		end else begin
			tw_vld_s <= vld_s[MT_M];
		end
	end

	always_ff @(posedge clk) begin
		tw_word_s <= y4;
		tw_side_s <= side_s[MT_M];
	end

	assign out_valid = tw_vld_s;
	assign out_word  = tw_word_s;
	assign out_side  = tw_side_s;

endmodule

/* hdl/svg_tail.sv */
// svg_tail: scaling of the tempered word into the fixed-point result
// multiply split over stages, divide by 100 by reciprocal multiplication, rounding and saturation
// depends on svg_pkg
module svg_tail import svg_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [31:0]        in_word,
	input  svg_side_t          in_side,
	input  logic [SCALE_W-1:0] variance_scale,
	output logic               out_valid,
	output logic [31:0]        out_value
);

	localparam int HA_W = HALF_RANGE_W + SCALE_W;
	localparam int PW   = 74;
	localparam int G    = 48 - OUT_FRAC_BITS;
	localparam int TW   = PW - G;
	localparam int QW   = TW - 15;
	localparam int RW   = (QW + 2 > 33) ? QW + 2 : 33;

	localparam int DL_W = 20;
	localparam int DH_W = QW - DL_W;
	localparam int DC_W = DL_W + 7;

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
	localparam logic [6:0]         DIV_K     = 7'd100;
	localparam logic [DL_W:0]      RCP_H     = (DL_W+1)'((64'd1 << DC_W) / 64'd100 + 64'd1);
	localparam logic [DC_W:0]      RCP_C     =
		(DC_W+1)'((64'd1 << (DC_W + 7)) / 64'd100 + 64'd1);

	localparam logic signed [RW-1:0] SAT_HI = RW'(64'sd2147483647);
	localparam logic signed [RW-1:0] SAT_LO = RW'(-64'sd2147483648);
	localparam logic signed [RW-1:0] ONE_FX = RW'(1) << OUT_FRAC_BITS;

	// stage 1: amount product and deviation magnitude
	logic [SCALE_W-1:0] amt;
	logic [32:0]        m_c;

	assign amt = variance_scale[SCALE_W-1] ? SCALE_ONE : variance_scale;
	assign m_c = in_word[31] ? {1'b0, in_word[30:0], 1'b0}
	                         : (33'h1_0000_0000 - {in_word, 1'b0});

	logic            vld_s1, neg_s1, op_s1;
	logic [HA_W-1:0] ha_s1;
	logic [32:0]     m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ha_s1  <= HA_W'(in_side.half_range) * HA_W'(amt);
		m_s1   <= m_c;
		neg_s1 <= ~in_word[31];
		op_s1  <= in_side.opcode;
	end

	// stage 2: partial products
	logic            vld_s2, neg_s2, op_s2, mtop_s2;
	logic [63:0]     pp0_s2;
	logic [40:0]     pp1_s2;
	logic [HA_W-1:0] ha_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp0_s2  <= 64'(ha_s1[31:0]) * 64'(m_s1[31:0]);
		pp1_s2  <= 41'(ha_s1[HA_W-1:32]) * 41'(m_s1[31:0]);
		mtop_s2 <= m_s1[32];
		ha_s2   <= ha_s1;
		neg_s2  <= neg_s1;
		op_s2   <= op_s1;
	end

	// stage 3: full product
	logic          vld_s3, neg_s3, op_s3;
	logic [PW-1:0] p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s3   <= PW'(pp0_s2) + PW'({pp1_s2, 32'h0})
		        + (mtop_s2 ? PW'({ha_s2, 32'h0}) : PW'(0));
		neg_s3 <= neg_s2;
		op_s3  <= op_s2;
	end

	// stage 4: rounding for raw output, dividend for multiplier output
	logic [TW-1:0] t_c;
	logic [TW:0]   r_c;

	assign t_c = p_s3[PW-1:G];
	assign r_c = {1'b0, t_c} + (TW+1)'(32768);

	logic          vld_s4, neg_s4, op_s4;
	logic [QW-1:0] mag1_s4, q_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		mag1_s4 <= r_c[TW:16];
		q_s4    <= QW'(t_c[TW-1:16]) + QW'(50);
		neg_s4  <= neg_s3;
		op_s4   <= op_s3;
	end

	// stage 5: high chunk times reciprocal of 100
	logic [DL_W-1:0] nh_c;

	assign nh_c = DL_W'(q_s4[QW-1:DL_W]);

	logic            vld_s5, neg_s5, op_s5;
	logic [QW-1:0]   mag1_s5;
	logic [DL_W-1:0] nh_s5, nl_s5;
	logic [2*DL_W:0] ph_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ph_s5   <= (2*DL_W+1)'(nh_c) * (2*DL_W+1)'(RCP_H);
		nh_s5   <= nh_c;
		nl_s5   <= q_s4[DL_W-1:0];
		mag1_s5 <= mag1_s4;
		neg_s5  <= neg_s4;
		op_s5   <= op_s4;
	end

	// stage 6: high quotient and remainder
	logic [2*DL_W-DC_W:0] qh_c;
	logic [DL_W-1:0]      rh_c;

	assign qh_c = ph_s5[2*DL_W:DC_W];
	assign rh_c = nh_s5 - DL_W'(qh_c) * DL_W'(DIV_K);

	logic            vld_s6, neg_s6, op_s6;
	logic [QW-1:0]   mag1_s6;
	logic [DH_W-1:0] qh_s6;
	logic [6:0]      rh_s6;
	logic [DL_W-1:0] nl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		qh_s6   <= DH_W'(qh_c);
		rh_s6   <= rh_c[6:0];
		nl_s6   <= nl_s5;
		mag1_s6 <= mag1_s5;
		neg_s6  <= neg_s5;
		op_s6   <= op_s5;
	end

	// stage 7: remainder joined with low chunk times reciprocal of 100
	logic [DC_W-1:0] c_c;

	assign c_c = {rh_s6, nl_s6};

	logic            vld_s7, neg_s7, op_s7;
	logic [QW-1:0]   mag1_s7;
	logic [DH_W-1:0] qh_s7;
	logic [2*DC_W:0] pc_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		pc_s7   <= (2*DC_W+1)'(c_c) * (2*DC_W+1)'(RCP_C);
		qh_s7   <= qh_s6;
		mag1_s7 <= mag1_s6;
		neg_s7  <= neg_s6;
		op_s7   <= op_s6;
	end

	// last stage: sign, offset and saturation
	logic [QW-1:0]         mag_c;
	logic signed [RW-1:0]  mag_x, base_c, res_c;
	logic [31:0]           sat_c;

	always_comb begin
		mag_c  = (op_s7 == OP_RAW) ? mag1_s7
		                           : {qh_s7, pc_s7[DC_W+7+DL_W-1:DC_W+7]};
		mag_x  = signed'(RW'(mag_c));
		base_c = (op_s7 == OP_RAW) ? RW'(0) : ONE_FX;
		res_c  = neg_s7 ? (base_c - mag_x) : (base_c + mag_x);
		if (res_c > SAT_HI) begin
			sat_c = 32'h7fff_ffff;
		end else if (res_c < SAT_LO) begin
			sat_c = 32'h8000_0000;
		end else begin
			sat_c = res_c[31:0];
		end
	end

	logic        vld_so;
	logic [31:0] value_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else begin
			vld_so <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		value_so <= sat_c;
	end

	assign out_valid = vld_so;
	assign out_value = value_so;

endmodule

/* hdl/seeded_variance_generator.sv */
// seeded_variance_generator: top level, configuration registers and entry stage
// depends on svg_pkg, svg_mt_chain, svg_tail
//
// usage
// - an input transfer happens at a rising edge with start high; busy stays low,
//   so a new key, half_range and opcode can be given in every cycle
// - each transfer produces exactly one result: done is high for one cycle with
//   variance_value valid, in the same order as the inputs
// - from the input transfer to done an item passes one entry stage, 397 seeding
//   stages, one tempering stage, four scaling stages, three divide stages and
//   one output stage
// - throughput is one item per cycle, set by the fully pipelined seeding chain
// - the receiver cannot hold results off; each result is shown for one cycle
// - configuration: cfg_we with cfg_addr 0 writes base_seed, cfg_addr 1 writes
//   variance_scale from cfg_wdata[16:0]; write only while no item is in flight
// - reset clears both registers and all stage valid bits; items in flight
//   are dropped
module seeded_variance_generator import svg_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [31:0]             key,
	input  logic [HALF_RANGE_W-1:0] half_range,
	input  logic                    opcode,
	input  logic                    cfg_we,
	input  logic                    cfg_addr,
	input  logic [31:0]             cfg_wdata,
	output logic                    done,
	output logic signed [31:0]      variance_value
);

	logic [31:0]        base_seed_q;
	logic [SCALE_W-1:0] variance_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seed_q      <= '0;
			variance_scale_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BASE_SEED:      base_seed_q      <= cfg_wdata;
				REG_VARIANCE_SCALE: variance_scale_q <= cfg_wdata[SCALE_W-1:0];
				default:            base_seed_q      <= base_seed_q;
			endcase
		end
	end

	assign busy = 1'b0;

	// entry stage: seed sum
	logic        vld_s0;
	logic [31:0] seed_s0;
	svg_side_t   side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		seed_s0            <= base_seed_q + key;
		side_s0.half_range <= half_range;
		side_s0.opcode     <= opcode;
	end

	logic        chain_vld;
	logic [31:0] chain_word;
	svg_side_t   chain_side;

	svg_mt_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s0),
		.in_seed   (seed_s0),
		.in_side   (side_s0),
		.out_valid (chain_vld),
		.out_word  (chain_word),
		.out_side  (chain_side)
	);

	logic [31:0] tail_value;

	svg_tail #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_tail (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (chain_vld),
		.in_word        (chain_word),
		.in_side        (chain_side),
		.variance_scale (variance_scale_q),
		.out_valid      (done),
		.out_value      (tail_value)
	);

	assign variance_value = signed'(tail_value);

endmodule
